// File: rtl/core/lrubc_pkg.sv
// ----------------------------------------------------------------------------
// lrubc_pkg: shared types and constants of the buffer cache tag engine
// Buffer count, index width, command and status codes, and the request,
// response and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package lrubc_pkg;

   localparam int BUFFER_COUNT = 32;
   localparam int IDX_W = (BUFFER_COUNT > 1) ? $clog2(BUFFER_COUNT) : 1;
   localparam int SLOT_W = 5;
   localparam int REF_W = 8;
   localparam logic [REF_W-1:0] REF_MAX = {REF_W{1'b1}};

   typedef logic [IDX_W-1:0] idx_type;

   typedef enum logic [1:0] {
      CMD_GET     = 2'd0,
      CMD_RELEASE = 2'd1,
      CMD_WRITE   = 2'd2,
      CMD_DONE    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK             = 2'd0,
      ST_NO_BUFFER      = 2'd1,
      ST_NOT_REFERENCED = 2'd2
   } status_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [7:0]        device_id;
      logic [31:0]       block_number;
      logic [SLOT_W-1:0] buffer_slot;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot_index;
      logic              was_hit;
      logic              read_needed;
      logic              write_needed;
      status_type        status;
   } rsp_type;

   // Commands from the controller to the datapath, one per phase.
   typedef struct packed {
      logic load;
      logic lookup;
      logic pick;
      logic exec;
      logic recent;
   } ctl_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic recent_needed;
   } dp_stat_type;

endpackage

// File: rtl/core/lrubc_ctrl.sv
// ----------------------------------------------------------------------------
// lrubc_ctrl: phase sequencer of the buffer cache tag engine
// Steps each request through lookup, pick and execute, and adds a recency
// update phase when a release drops the last reference.
// ----------------------------------------------------------------------------
module lrubc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  lrubc_pkg::dp_stat_type stat,
   output logic                  busy,
   output lrubc_pkg::ctl_type    ctl
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOKUP,
      S_PICK,
      S_EXEC,
      S_RECENT
   } state_type;

   state_type state_ff;
   logic      busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  state_ff <= S_LOOKUP;
                  busy_ff  <= 1'b1;
               end
            end
            S_LOOKUP: begin
               state_ff <= S_PICK;
            end
            S_PICK: begin
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               if (stat.recent_needed) begin
                  state_ff <= S_RECENT;
               end else begin
                  state_ff <= S_IDLE;
                  busy_ff  <= 1'b0;
               end
            end
            S_RECENT: begin
               state_ff <= S_IDLE;
               busy_ff  <= 1'b0;
            end
            default: begin
               state_ff <= S_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

   assign busy       = busy_ff;
   assign ctl.load   = start && !busy_ff;
   assign ctl.lookup = (state_ff == S_LOOKUP);
   assign ctl.pick   = (state_ff == S_PICK);
   assign ctl.exec   = (state_ff == S_EXEC);
   assign ctl.recent = (state_ff == S_RECENT);

endmodule

// File: rtl/core/lrubc_datapath.sv
// ----------------------------------------------------------------------------
// lrubc_datapath: tag store, reference counts and recency order
// Holds the per-entry state, compares tags in parallel, picks the entry by
// recency and applies each command's update and response.
// ----------------------------------------------------------------------------
module lrubc_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  lrubc_pkg::ctl_type     ctl,
   input  lrubc_pkg::req_type     req_data,
   output lrubc_pkg::dp_stat_type stat,
   output logic                   rsp_strobe,
   output lrubc_pkg::rsp_type     rsp_data
);

   localparam int N = lrubc_pkg::BUFFER_COUNT;

   // Per-entry state. order_ff[r] is the entry that holds recency rank r,
   // rank N-1 being the most recent.
   logic [7:0]                  tag_dev_ff [N];
   logic [31:0]                 tag_blk_ff [N];
   logic [lrubc_pkg::REF_W-1:0] ref_ff     [N];
   logic                        valid_ff   [N];
   logic                        dirty_ff   [N];
   lrubc_pkg::idx_type          order_ff   [N];

   lrubc_pkg::req_type req_ff;
   logic [N-1:0]       hit_vec_ff;
   logic [N-1:0]       free_vec_ff;
   lrubc_pkg::idx_type target_ff;
   logic               hit_found_ff;
   logic               free_found_ff;
   lrubc_pkg::rsp_type rsp_ff;
   logic               strobe_ff;

   // Lookup: match and free flags per entry, then rearranged by rank.
   logic [N-1:0] match;
   logic [N-1:0] free;
   logic [N-1:0] hit_vec_in;
   logic [N-1:0] free_vec_in;

   always_comb begin
      for (int i = 0; i < N; i++) begin
         match[i] = (tag_dev_ff[i] == req_ff.device_id) &&
                    (tag_blk_ff[i] == req_ff.block_number);
         free[i]  = (ref_ff[i] == '0) && !dirty_ff[i];
      end
      for (int r = 0; r < N; r++) begin
         hit_vec_in[r]  = match[order_ff[r]];
         free_vec_in[r] = free[order_ff[r]];
      end
   end

   // Pick: highest-rank match, lowest-rank free entry.
   lrubc_pkg::idx_type hit_rank;
   lrubc_pkg::idx_type free_rank;
   lrubc_pkg::idx_type target_in;

   always_comb begin
      hit_rank  = '0;
      free_rank = '0;
      for (int r = 0; r < N; r++) begin
         if (hit_vec_ff[r]) begin
            hit_rank = lrubc_pkg::IDX_W'(r);
         end
      end
      for (int r = N - 1; r >= 0; r--) begin
         if (free_vec_ff[r]) begin
            free_rank = lrubc_pkg::IDX_W'(r);
         end
      end
      if (req_ff.cmd != lrubc_pkg::CMD_GET) begin
         target_in = lrubc_pkg::IDX_W'(req_ff.buffer_slot);
      end else if (|hit_vec_ff) begin
         target_in = order_ff[hit_rank];
      end else begin
         target_in = order_ff[free_rank];
      end
   end

   // Execute: read the target entry and decide updates and the response.
   logic                        slot_ok;
   logic [lrubc_pkg::REF_W-1:0] cur_ref;
   logic                        cur_valid;
   logic                        upd_tag;
   logic                        upd_ref;
   logic [lrubc_pkg::REF_W-1:0] ref_val;
   logic                        upd_valid;
   logic                        valid_val;
   logic                        upd_dirty;
   logic                        dirty_val;
   logic                        recent_needed;
   lrubc_pkg::rsp_type          rsp_in;

   always_comb begin
      slot_ok       = int'(req_ff.buffer_slot) < N;
      cur_ref       = ref_ff[target_ff];
      cur_valid     = valid_ff[target_ff];
      upd_tag       = 1'b0;
      upd_ref       = 1'b0;
      ref_val       = cur_ref;
      upd_valid     = 1'b0;
      valid_val     = 1'b0;
      upd_dirty     = 1'b0;
      dirty_val     = 1'b0;
      recent_needed = 1'b0;
      rsp_in.slot_index   = req_ff.buffer_slot;
      rsp_in.was_hit      = 1'b0;
      rsp_in.read_needed  = 1'b0;
      rsp_in.write_needed = 1'b0;
      rsp_in.status       = lrubc_pkg::ST_OK;
      case (req_ff.cmd)
         lrubc_pkg::CMD_GET: begin
            if (hit_found_ff) begin
               upd_ref = 1'b1;
               if (cur_ref != lrubc_pkg::REF_MAX) begin
                  ref_val = cur_ref + 1'b1;
               end
               rsp_in.slot_index  = lrubc_pkg::SLOT_W'(target_ff);
               rsp_in.was_hit     = 1'b1;
               rsp_in.read_needed = !cur_valid;
            end else if (free_found_ff) begin
               upd_tag   = 1'b1;
               upd_ref   = 1'b1;
               ref_val   = lrubc_pkg::REF_W'(1);
               upd_valid = 1'b1;
               upd_dirty = 1'b1;
               rsp_in.slot_index  = lrubc_pkg::SLOT_W'(target_ff);
               rsp_in.read_needed = 1'b1;
            end else begin
               rsp_in.slot_index = '0;
               rsp_in.status     = lrubc_pkg::ST_NO_BUFFER;
            end
         end
         lrubc_pkg::CMD_DONE: begin
            if (slot_ok) begin
               upd_valid = 1'b1;
               valid_val = 1'b1;
               upd_dirty = 1'b1;
            end
         end
         lrubc_pkg::CMD_WRITE: begin
            if (!slot_ok || cur_ref == '0) begin
               rsp_in.status = lrubc_pkg::ST_NOT_REFERENCED;
            end else begin
               upd_dirty = 1'b1;
               dirty_val = 1'b1;
               rsp_in.write_needed = 1'b1;
            end
         end
         lrubc_pkg::CMD_RELEASE: begin
            if (!slot_ok || cur_ref == '0) begin
               rsp_in.status = lrubc_pkg::ST_NOT_REFERENCED;
            end else begin
               upd_ref       = 1'b1;
               ref_val       = cur_ref - 1'b1;
               recent_needed = (cur_ref == lrubc_pkg::REF_W'(1));
            end
         end
         default: begin
            rsp_in.status = lrubc_pkg::ST_OK;
         end
      endcase
   end

   assign stat.recent_needed = ctl.exec && recent_needed;

   // Recency update: find the target's rank, shift the ranks above it down
   // and put the target at the top.
   lrubc_pkg::idx_type rank_pos;
   logic [N-1:0]       shift_mask;

   always_comb begin
      rank_pos = '0;
      for (int r = 0; r < N; r++) begin
         if (order_ff[r] == target_ff) begin
            rank_pos = rank_pos | lrubc_pkg::IDX_W'(r);
         end
      end
      for (int r = 0; r < N; r++) begin
         shift_mask[r] = (lrubc_pkg::IDX_W'(r) >= rank_pos);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         req_ff <= req_data;
      end
      if (ctl.lookup) begin
         hit_vec_ff  <= hit_vec_in;
         free_vec_ff <= free_vec_in;
      end
      if (ctl.pick) begin
         target_ff     <= target_in;
         hit_found_ff  <= |hit_vec_ff;
         free_found_ff <= |free_vec_ff;
      end
      if (ctl.exec) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= ctl.exec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) begin
            tag_dev_ff[i] <= '0;
            tag_blk_ff[i] <= '0;
            ref_ff[i]     <= '0;
            valid_ff[i]   <= 1'b0;
            dirty_ff[i]   <= 1'b0;
            order_ff[i]   <= lrubc_pkg::IDX_W'(i);
         end
      end else begin
         if (ctl.exec) begin
            for (int i = 0; i < N; i++) begin
               if (target_ff == lrubc_pkg::IDX_W'(i)) begin
                  if (upd_tag) begin
                     tag_dev_ff[i] <= req_ff.device_id;
                     tag_blk_ff[i] <= req_ff.block_number;
                  end
                  if (upd_ref) begin
                     ref_ff[i] <= ref_val;
                  end
                  if (upd_valid) begin
                     valid_ff[i] <= valid_val;
                  end
                  if (upd_dirty) begin
                     dirty_ff[i] <= dirty_val;
                  end
               end
            end
         end
         if (ctl.recent) begin
            for (int r = 0; r < N - 1; r++) begin
               if (shift_mask[r]) begin
                  order_ff[r] <= order_ff[r + 1];
               end
            end
            order_ff[N - 1] <= target_ff;
         end
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// File: rtl/core/lru_block_buffer_cache_core.sv
// ----------------------------------------------------------------------------
// lru_block_buffer_cache_core: buffer cache tag engine with reference counts
// A request is taken while busy is low and runs through the lookup, pick,
// execute and, when a release drops the last reference, recency update
// phases; its response is shown for one cycle on rsp_strobe. A new request
// is not taken until the last one is through.
// Reset clears all tags, counts and flags and restores rank i to entry i.
// The receiver cannot stall, so the response strobe is never held back.
// ----------------------------------------------------------------------------
module lru_block_buffer_cache_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  lrubc_pkg::req_type req_data,
   output logic               rsp_strobe,
   output lrubc_pkg::rsp_type rsp_data
);

   // The controller sequences the phases of each request; the datapath owns
   // every piece of per-entry state. They talk only through ctl and stat.
   //
   // Lookup compares the request's tag against all entries in parallel and
   // lays the match and free flags out by recency rank. Pick takes the given
   // slot or, for a get, the highest-rank match or else the lowest-rank entry
   // that is clean and unreferenced. Execute reads that one entry, updates it
   // and registers the response. When a release drops the last reference, one
   // more phase moves the entry to the top of the recency order.
   lrubc_pkg::ctl_type     ctl;
   lrubc_pkg::dp_stat_type stat;

   lrubc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy),
      .ctl   (ctl)
   );

   lrubc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .req_data   (req_data),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // Every accepted request is followed by a response strobe.
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_strobe)
      else $error("response did not follow an accepted request");

   // Response strobes never come back to back.
   a_rsp_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("back-to-back response strobes");

   // No new request is taken while one is in progress.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after an accepted request");

   // A hit always completes with status ok and never asks for a disk write.
   a_hit_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.was_hit) |->
         (rsp_data.status == lrubc_pkg::ST_OK && !rsp_data.write_needed))
      else $error("hit response with bad status");

endmodule

// File: dv/lrubc_tag_checker.sv
// ----------------------------------------------------------------------------
// lrubc_tag_checker: response predictor and comparator for the tag engine
// Keeps its own copy of tags, reference counts, valid/dirty flags and recency
// ranks, predicts the response of every accepted request and compares it field
// by field with the response strobed out of the block.
// ----------------------------------------------------------------------------
module lrubc_tag_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  lrubc_pkg::req_type req_data,
   input  logic               rsp_strobe,
   input  lrubc_pkg::rsp_type rsp_data,
   output int                 fail_count,
   output int                 pending_count,
   output int                 checked_count,
   output int                 hit_count,
   output int                 no_buffer_count,
   output int                 unref_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import lrubc_pkg::*;

   logic [7:0]       cached_dev [BUFFER_COUNT];
   logic [31:0]      cached_blk [BUFFER_COUNT];
   logic [REF_W-1:0] holders    [BUFFER_COUNT];
   logic             data_valid [BUFFER_COUNT];
   logic             data_dirty [BUFFER_COUNT];
   int               rank_q     [BUFFER_COUNT];

   rsp_type expected_rsp_q[$];

   // Applies one request to the shadow state and returns the response it owes.
   function automatic rsp_type serve_request(req_type r);
      rsp_type rsp;
      int      pick;
      int      slot;
      int      old_rank;
      int      i;
      rsp = '0;
      rsp.status = ST_OK;
      slot = int'(r.buffer_slot);
      pick = -1;
      case (r.cmd)
         CMD_GET: begin
            // Tags are compared without regard to the valid flag; the most
            // recent match wins.
            for (i = 0; i < BUFFER_COUNT; i++)
               if (cached_dev[i] == r.device_id && cached_blk[i] == r.block_number &&
                   (pick < 0 || rank_q[i] > rank_q[pick]))
                  pick = i;
            if (pick >= 0) begin
               if (holders[pick] != REF_MAX)
                  holders[pick] = holders[pick] + 1'b1;
               rsp.slot_index  = SLOT_W'(pick);
               rsp.was_hit     = 1'b1;
               rsp.read_needed = !data_valid[pick];
            end else begin
               for (i = 0; i < BUFFER_COUNT; i++)
                  if (holders[i] == '0 && !data_dirty[i] &&
                      (pick < 0 || rank_q[i] < rank_q[pick]))
                     pick = i;
               if (pick < 0) begin
                  rsp.status = ST_NO_BUFFER;
               end else begin
                  cached_dev[pick] = r.device_id;
                  cached_blk[pick] = r.block_number;
                  holders[pick]    = REF_W'(1);
                  data_valid[pick] = 1'b0;
                  data_dirty[pick] = 1'b0;
                  rsp.slot_index   = SLOT_W'(pick);
                  rsp.read_needed  = 1'b1;
               end
            end
         end
         CMD_DONE: begin
            rsp.slot_index = r.buffer_slot;
            if (slot < BUFFER_COUNT) begin
               data_valid[slot] = 1'b1;
               data_dirty[slot] = 1'b0;
            end
         end
         default: begin
            rsp.slot_index = r.buffer_slot;
            if (slot >= BUFFER_COUNT || holders[slot] == '0) begin
               rsp.status = ST_NOT_REFERENCED;
            end else if (r.cmd == CMD_WRITE) begin
               data_dirty[slot] = 1'b1;
               rsp.write_needed = 1'b1;
            end else begin
               holders[slot] = holders[slot] - 1'b1;
               if (holders[slot] == '0) begin
                  old_rank = rank_q[slot];
                  for (i = 0; i < BUFFER_COUNT; i++)
                     if (rank_q[i] > old_rank)
                        rank_q[i] = rank_q[i] - 1;
                  rank_q[slot] = BUFFER_COUNT - 1;
               end
            end
         end
      endcase
      return rsp;
   endfunction

   task automatic note_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   task automatic check_response(rsp_type got);
      rsp_type want;
      if (expected_rsp_q.size() == 0) begin
         $display("%0t: unexpected response: expected none, actual slot %0d status %0d",
                  $time, got.slot_index, got.status);
         fail_count++;
      end else begin
         want = expected_rsp_q.pop_front();
         checked_count++;
         if (want.was_hit) hit_count++;
         if (want.status == ST_NO_BUFFER) no_buffer_count++;
         if (want.status == ST_NOT_REFERENCED) unref_count++;
         note_field("slot_index", want.slot_index, got.slot_index);
         note_field("was_hit", want.was_hit, got.was_hit);
         note_field("read_needed", want.read_needed, got.read_needed);
         note_field("write_needed", want.write_needed, got.write_needed);
         note_field("status", want.status, got.status);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BUFFER_COUNT; i++) begin
            cached_dev[i] = '0;
            cached_blk[i] = '0;
            holders[i]    = '0;
            data_valid[i] = 1'b0;
            data_dirty[i] = 1'b0;
            rank_q[i]     = i;
         end
         expected_rsp_q.delete();
      end else begin
         // A response strobed at this edge belongs to an older request, so it
         // is checked before a request accepted at the same edge is queued.
         if (rsp_strobe)
            check_response(rsp_data);
         if (start && !busy)
            expected_rsp_q.push_back(serve_request(req_data));
      end
      pending_count <= expected_rsp_q.size();
   end

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench top of the buffer cache tag engine
// Drives directed and random get, release, write and disk-done requests with
// random idle bursts, while a separate checker predicts and compares every
// response. A watchdog ends the run when traffic stops.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lrubc_pkg::*;

   localparam int ITEM_TARGET    = 1750;
   localparam int CALM_TAIL      = 150;
   localparam int HAMMER_GETS    = 260;
   localparam int POOL_SIZE      = 40;
   localparam int SETTLE_CYCLES  = 12;
   localparam int WATCHDOG_LIMIT = 1000;

   // Random traffic comes in phases: filling the cache until it runs out of
   // recyclable buffers, draining references again, or an even mix.
   typedef enum logic [1:0] {
      PH_FILL,
      PH_DRAIN,
      PH_MIXED
   } phase_type;

   logic    clock;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   int fail_count;
   int pending_count;
   int checked_count;
   int hit_count;
   int no_buffer_count;
   int unref_count;

   int sent_total;
   int sent_by_cmd[4];
   bit idling_on;

   // Slots the stimulus believes it holds a reference to, and slots that owe
   // a disk transfer (a read after a get, a write after a write request).
   logic [SLOT_W-1:0] owned_slots[$];
   logic [SLOT_W-1:0] io_slots[$];

   // A small pool of tags makes gets hit cached blocks; it is larger than the
   // cache so that entries also get recycled.
   logic [7:0]  pool_dev[POOL_SIZE];
   logic [31:0] pool_blk[POOL_SIZE];

   wire accepted = start && !busy;

   lru_block_buffer_cache_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   lrubc_tag_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_data        (req_data),
      .rsp_strobe      (rsp_strobe),
      .rsp_data        (rsp_data),
      .fail_count      (fail_count),
      .pending_count   (pending_count),
      .checked_count   (checked_count),
      .hit_count       (hit_count),
      .no_buffer_count (no_buffer_count),
      .unref_count     (unref_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // The stimulus learns which slots it was granted from the responses, so
   // that most releases and writes target buffers that are really held.
   always @(posedge clock) begin
      if (!reset && rsp_strobe && rsp_data.status == ST_OK) begin
         if (rsp_data.was_hit || rsp_data.read_needed)
            owned_slots.push_back(rsp_data.slot_index);
         if (rsp_data.read_needed)
            io_slots.push_back(rsp_data.slot_index);
      end
   end

   // The watchdog counts cycles in which neither a request nor a response
   // moves; a hung block or a lost response ends the run here.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || accepted || rsp_strobe)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: watchdog expired with %0d responses outstanding", $time, pending_count);
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic logic [SLOT_W-1:0] any_slot();
      return SLOT_W'($urandom_range(0, BUFFER_COUNT - 1));
   endfunction

   function automatic logic [7:0] any_dev();
      return 8'($urandom());
   endfunction

   function automatic req_type make_req(cmd_type cmd, logic [7:0] dev, logic [31:0] blk,
                                        logic [SLOT_W-1:0] slot);
      req_type r;
      r.cmd          = cmd;
      r.device_id    = dev;
      r.block_number = blk;
      r.buffer_slot  = slot;
      return r;
   endfunction

   // Builds one random request. Fields that the command ignores are still
   // random, so every input bit toggles. About one release or write in ten
   // goes to a random slot, which is usually unreferenced.
   function automatic req_type random_request(phase_type phase);
      req_type r;
      int      roll;
      int      get_lim;
      int      rel_lim;
      int      wr_lim;
      int      pos;
      r = make_req(CMD_GET, 8'($urandom_range(0, 255)), $urandom(), any_slot());
      roll = $urandom_range(0, 99);
      case (phase)
         PH_FILL:  begin get_lim = 55; rel_lim = 65; wr_lim = 80; end
         PH_DRAIN: begin get_lim = 20; rel_lim = 65; wr_lim = 72; end
         default:  begin get_lim = 40; rel_lim = 65; wr_lim = 78; end
      endcase
      if (roll < get_lim) begin
         if ($urandom_range(0, 9) < 6) begin
            pos = $urandom_range(0, POOL_SIZE - 1);
            r.device_id    = pool_dev[pos];
            r.block_number = pool_blk[pos];
         end
      end else if (roll < rel_lim) begin
         r.cmd = CMD_RELEASE;
         if (owned_slots.size() > 0 && $urandom_range(0, 9) != 0) begin
            pos = $urandom_range(0, owned_slots.size() - 1);
            r.buffer_slot = owned_slots[pos];
            owned_slots.delete(pos);
         end
      end else if (roll < wr_lim) begin
         r.cmd = CMD_WRITE;
         if (owned_slots.size() > 0 && $urandom_range(0, 9) != 0)
            r.buffer_slot = owned_slots[$urandom_range(0, owned_slots.size() - 1)];
         io_slots.push_back(r.buffer_slot);
      end else begin
         r.cmd = CMD_DONE;
         if (io_slots.size() > 0 && $urandom_range(0, 4) != 0) begin
            pos = $urandom_range(0, io_slots.size() - 1);
            r.buffer_slot = io_slots[pos];
            io_slots.delete(pos);
         end
      end
      return r;
   endfunction

   // Presents one request and returns at the edge that accepts it. The idle
   // burst, if any, lowers start first; otherwise start stays high and only
   // the payload changes, so start never sees two assignments in one step.
   task automatic issue(req_type r);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      sent_total++;
      sent_by_cmd[r.cmd]++;
   endtask

   // Lowers start and waits until every queued response has been checked.
   // The first edge lets the checker count the request accepted just now.
   task automatic quiesce();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      phase_type   phase;
      int          phase_left;
      logic [31:0] hammer_blk;
      for (int i = 0; i < POOL_SIZE; i++) begin
         pool_dev[i] = 8'($urandom_range(0, 255));
         pool_blk[i] = $urandom();
      end
      // Tag extremes, including the all-zero tag that every entry holds after
      // reset.
      pool_dev[0] = 8'h00; pool_blk[0] = 32'h0000_0000;
      pool_dev[1] = 8'hFF; pool_blk[1] = 32'hFFFF_FFFF;
      pool_dev[2] = 8'h00; pool_blk[2] = 32'hFFFF_FFFF;
      pool_dev[3] = 8'hFF; pool_blk[3] = 32'h0000_0000;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Right after reset every entry carries the zero tag, so
      // a get of device 0 block 0 hits the most recent of the many matches
      // and still needs a read, since nothing is valid yet.
      idling_on = 1'b1;
      issue(make_req(CMD_GET, 8'h00, 32'h0, any_slot()));
      issue(make_req(CMD_RELEASE, any_dev(), $urandom(), SLOT_W'(BUFFER_COUNT - 1)));
      // The same release again finds no reference left.
      issue(make_req(CMD_RELEASE, any_dev(), $urandom(), SLOT_W'(BUFFER_COUNT - 1)));
      // A write to an unreferenced entry is flagged and asks for no disk write.
      issue(make_req(CMD_WRITE, any_dev(), $urandom(), 5'd5));
      // Disk done acts even on an unreferenced entry.
      issue(make_req(CMD_DONE, any_dev(), $urandom(), 5'd0));
      // A miss recycles the least recent clean entry; the repeat then hits it.
      issue(make_req(CMD_GET, 8'hFF, 32'hFFFF_FFFF, any_slot()));
      issue(make_req(CMD_GET, 8'hFF, 32'hFFFF_FFFF, any_slot()));
      issue(make_req(CMD_DONE, any_dev(), $urandom(), 5'd0));
      // Now the data is valid, so a further hit needs no read.
      issue(make_req(CMD_GET, 8'hFF, 32'hFFFF_FFFF, any_slot()));
      issue(make_req(CMD_WRITE, any_dev(), $urandom(), 5'd0));
      // Dropping the last reference makes the entry most recent; it stays
      // dirty, so the next miss must skip it.
      repeat (3) issue(make_req(CMD_RELEASE, any_dev(), $urandom(), 5'd0));
      issue(make_req(CMD_GET, 8'h01, 32'h8000_0000, any_slot()));
      issue(make_req(CMD_DONE, any_dev(), $urandom(), 5'd0));
      issue(make_req(CMD_GET, 8'hAA, 32'h5555_5555, any_slot()));
      issue(make_req(CMD_GET, 8'h55, 32'hAAAA_AAAA, any_slot()));
      issue(make_req(CMD_DONE, any_dev(), $urandom(), SLOT_W'(BUFFER_COUNT - 1)));
      issue(make_req(CMD_WRITE, any_dev(), $urandom(), SLOT_W'(BUFFER_COUNT - 1)));
      issue(make_req(CMD_RELEASE, any_dev(), $urandom(), 5'd1));
      issue(make_req(CMD_WRITE, any_dev(), $urandom(), 5'd1));
      issue(make_req(CMD_RELEASE, any_dev(), $urandom(), 5'd1));

      // Hammer one block with gets so that its reference count saturates,
      // then hand back every reference the stimulus holds. The releases past
      // the saturated count run into an unreferenced entry.
      owned_slots.delete();
      io_slots.delete();
      hammer_blk = $urandom();
      repeat (HAMMER_GETS) issue(make_req(CMD_GET, 8'hFE, hammer_blk, any_slot()));
      quiesce();
      while (owned_slots.size() > 0)
         issue(make_req(CMD_RELEASE, any_dev(), $urandom(), owned_slots.pop_back()));

      // Random part in phases of random length, each with or without idling;
      // the tail of the run goes back to back.
      phase_left = 0;
      while (sent_total < ITEM_TARGET) begin
         if (phase_left == 0) begin
            phase      = phase_type'($urandom_range(0, 2));
            phase_left = $urandom_range(80, 200);
            idling_on  = ($urandom_range(0, 2) != 0);
         end
         if (sent_total >= ITEM_TARGET - CALM_TAIL)
            idling_on = 1'b0;
         issue(random_request(phase));
         phase_left--;
      end

      // Wait out the remaining responses, then let the clock run on for a settling
      // time so that a stray extra response would still be caught.
      quiesce();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d requests: %0d gets, %0d releases, %0d writes, %0d disk-done.",
               sent_total, sent_by_cmd[CMD_GET], sent_by_cmd[CMD_RELEASE],
               sent_by_cmd[CMD_WRITE], sent_by_cmd[CMD_DONE]);
      $display("Checked %0d responses: %0d hits, %0d without a free buffer, %0d unreferenced.",
               checked_count, hit_count, no_buffer_count, unref_count);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
